// File: rtl/core/irsa_pkg.sv
// shared codes and fixed widths for the rotating scatter-address generator
package irsa_pkg;

	localparam int BYTE_W  = 8;
	localparam int ADDR_W  = 26;
	localparam int CFG_W   = 13;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_LAYOUT = 2'd3;

	// rotation codes
	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_90   = 2'd1;
	localparam logic [1:0] ROT_180  = 2'd2;
	localparam logic [1:0] ROT_270  = 2'd3;

	// pixel layout codes
	localparam logic [1:0] LAYOUT_PLANAR = 2'd0;
	localparam logic [1:0] LAYOUT_SEMI   = 2'd1;
	localparam logic [1:0] LAYOUT_RGB    = 2'd2;
	localparam logic [1:0] LAYOUT_RGBA   = 2'd3;

	// plane codes
	localparam logic [1:0] PLANE_LUMA = 2'd0;
	localparam logic [1:0] PLANE_U    = 2'd1;
	localparam logic [1:0] PLANE_V    = 2'd2;

	localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
	localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

endpackage

// File: rtl/core/irsa_in_if.sv
// source byte channel
interface irsa_in_if
	import irsa_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] source_byte;

	modport source (output valid, output source_byte, input ready);
	modport sink (input valid, input source_byte, output ready);
endinterface

// File: rtl/core/irsa_out_if.sv
// scattered result channel: destination address, byte and frame end
interface irsa_out_if
	import irsa_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] dest_address;
	logic [BYTE_W-1:0] out_byte;
	logic              frame_end;

	modport source (output valid, output dest_address, output out_byte, output frame_end,
		input ready);
	modport sink (input valid, input dest_address, input out_byte, input frame_end,
		output ready);
endinterface

// File: rtl/core/image_rotate_scatter_address.sv
// rotating scatter-address generator: top level
//
// Source frame bytes enter in memory order on byte_stream, one per transfer, and
// each leaves on addr_stream with its byte offset in the frame rotated clockwise
// by 90, 180 or 270 degrees, the byte itself and a frame_end flag on the last
// byte of the last plane. Layouts: planar yuv420 (Y, U, V), semi-planar yuv420
// (Y, interleaved UV), rgb (3 bytes a pixel), rgba (4 bytes a pixel). The block
// takes one byte every cycle while the output register is free or being emptied, and
// a result passes the operand, index and output registers before it can leave; the pipeline is input counters,
// one index multiplier stage and a base/byte-scale adder stage into the output
// register, and it only stops when the output register is full and not taken.
// With rotation set to none bytes are taken and dropped and the position
// counters stay put. Any configuration write restarts the frame. Width and
// height have their low bit cleared and are held between 2 and MAX_DIM; the
// address wraps at 2^26.
module image_rotate_scatter_address
	import irsa_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	irsa_in_if.sink              byte_stream,
	irsa_out_if.source           addr_stream
);

	// dimension widths: a dimension holds MAX_DIM, a position stays below it
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int CNT_W  = $clog2(MAX_DIM);
	localparam int AREA_W = 2 * CNT_W;
	localparam int SUM_W  = AREA_W + 3;
	localparam int CW     = (DIM_W > CFG_W) ? DIM_W : CFG_W;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [CW-1:0] e;
		e = CW'({v[CFG_W-1:1], 1'b0});
		if (e < CW'(2))
			e = CW'(2);
		if (e > CW'(MAX_DIM))
			e = CW'(MAX_DIM);
		return e[DIM_W-1:0];
	endfunction

	// configuration registers, dimensions kept already clamped
	logic [DIM_W-1:0]  width_q, height_q;
	logic [1:0]        rotation_q, layout_q;
	// luma area reaches MAX_DIM squared, one bit above a pixel index
	logic [AREA_W:0]   area_q;

	// position counters
	logic [CNT_W-1:0] col_q, row_q;
	logic [1:0]       bip_q, plane_q;

	// stage 1: multiplier operands
	logic              v_s1;
	logic [CNT_W-1:0]  mul_a_s1, add_c_s1;
	logic [DIM_W-1:0]  mul_b_s1;
	logic [2:0]        bpp_s1;
	logic [1:0]        bip_s1, plane_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// stage 2: pixel index and plane base
	logic              v_s2;
	logic [AREA_W-1:0] idx_s2;
	logic [AREA_W:0]   base_s2;
	logic [2:0]        bpp_s2;
	logic [1:0]        bip_s2;
	logic [BYTE_W-1:0] byte_s2;
	logic              last_s2;

	// stage 3: output register
	logic              v_s3;
	logic [ADDR_W-1:0] addr_s3;
	logic [BYTE_W-1:0] byte_s3;
	logic              last_s3;

	// current plane geometry
	logic             chroma;
	logic [DIM_W-1:0] pw_cur, ph_cur;
	logic [2:0]       bpp_cur;
	logic [1:0]       nplanes;

	// counter stepping
	logic             adv, take, work;
	logic [2:0]       bip_inc;
	logic [DIM_W-1:0] col_inc, row_inc;
	logic [2:0]       plane_inc;
	logic             pix_done, row_done, plane_done, frame_done;

	// stage 0 operands
	logic [DIM_W-1:0] ph_m1_y, pw_m1_x;
	logic [CNT_W-1:0] op_a, op_c;
	logic [DIM_W-1:0] op_b;

	// later stage math
	logic [CNT_W+DIM_W-1:0] product;
	logic [AREA_W:0]        base_nxt;
	logic [SUM_W-1:0]       scaled, addr_sum;

	// whole pipeline moves when the output register is free or being emptied
	assign adv  = !v_s3 || addr_stream.ready;
	assign take = byte_stream.valid && adv;
	assign work = take && (rotation_q != ROT_NONE);

	assign byte_stream.ready        = adv;
	assign addr_stream.valid        = v_s3;
	assign addr_stream.dest_address = addr_s3;
	assign addr_stream.out_byte     = byte_s3;
	assign addr_stream.frame_end    = last_s3;

	always_comb begin
		chroma  = (plane_q != PLANE_LUMA);
		pw_cur  = chroma ? (width_q >> 1) : width_q;
		ph_cur  = chroma ? (height_q >> 1) : height_q;
		case (layout_q)
			LAYOUT_PLANAR: begin
				nplanes = 2'd3;
				bpp_cur = 3'd1;
			end
			LAYOUT_SEMI: begin
				nplanes = 2'd2;
				bpp_cur = chroma ? 3'd2 : 3'd1;
			end
			LAYOUT_RGB: begin
				nplanes = 2'd1;
				bpp_cur = 3'd3;
			end
			default: begin
				nplanes = 2'd1;
				bpp_cur = 3'd4;
			end
		endcase
	end

	// carry chain: byte in pixel, column, row, plane
	always_comb begin
		bip_inc    = {1'b0, bip_q} + 3'd1;
		col_inc    = DIM_W'(col_q) + DIM_W'(1);
		row_inc    = DIM_W'(row_q) + DIM_W'(1);
		plane_inc  = {1'b0, plane_q} + 3'd1;
		pix_done   = (bip_inc >= bpp_cur);
		row_done   = pix_done && (col_inc >= pw_cur);
		plane_done = row_done && (row_inc >= ph_cur);
		frame_done = plane_done && (plane_inc >= {1'b0, nplanes});
	end

	// multiplier operands per rotation: index = a * b + c
	always_comb begin
		ph_m1_y = ph_cur - DIM_W'(1) - DIM_W'(row_q);
		pw_m1_x = pw_cur - DIM_W'(1) - DIM_W'(col_q);
		case (rotation_q)
			ROT_90: begin
				op_a = col_q;
				op_b = ph_cur;
				op_c = ph_m1_y[CNT_W-1:0];
			end
			ROT_180: begin
				op_a = ph_m1_y[CNT_W-1:0];
				op_b = pw_cur;
				op_c = pw_m1_x[CNT_W-1:0];
			end
			default: begin
				op_a = pw_m1_x[CNT_W-1:0];
				op_b = ph_cur;
				op_c = row_q;
			end
		endcase
	end

	always_comb begin
		product = CNT_W'(mul_a_s1) * (CNT_W+DIM_W)'(mul_b_s1);
		case (plane_s1)
			PLANE_U: base_nxt = area_q;
			PLANE_V: base_nxt = area_q + (area_q >> 2);
			default: base_nxt = '0;
		endcase
		case (bpp_s2)
			3'd2:    scaled = SUM_W'(idx_s2) << 1;
			3'd3:    scaled = SUM_W'(idx_s2) + (SUM_W'(idx_s2) << 1);
			3'd4:    scaled = SUM_W'(idx_s2) << 2;
			default: scaled = SUM_W'(idx_s2);
		endcase
		addr_sum = scaled + SUM_W'(base_s2) + SUM_W'(bip_s2);
	end

	// configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= clamp_dim(RESET_WIDTH);
			height_q   <= clamp_dim(RESET_HEIGHT);
			rotation_q <= ROT_NONE;
			layout_q   <= LAYOUT_PLANAR;
			col_q      <= '0;
			row_q      <= '0;
			bip_q      <= '0;
			plane_q    <= PLANE_LUMA;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q    <= clamp_dim(cfg_data);
				REG_FRAME_HEIGHT: height_q   <= clamp_dim(cfg_data);
				REG_ROTATION:     rotation_q <= cfg_data[1:0];
				REG_PIXEL_LAYOUT: layout_q   <= cfg_data[1:0];
				default:          ;
			endcase
			// any write restarts the frame
			col_q   <= '0;
			row_q   <= '0;
			bip_q   <= '0;
			plane_q <= PLANE_LUMA;
		end else if (work) begin
			bip_q <= pix_done ? 2'd0 : bip_inc[1:0];
			if (pix_done)
				col_q <= row_done ? '0 : col_inc[CNT_W-1:0];
			if (row_done)
				row_q <= plane_done ? '0 : row_inc[CNT_W-1:0];
			if (plane_done)
				plane_q <= frame_done ? PLANE_LUMA : plane_inc[1:0];
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= work;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// pipeline payload, plus luma area tracking the dimension registers
	always_ff @(posedge clk) begin
		area_q <= (AREA_W+1)'(width_q) * (AREA_W+1)'(height_q);
		if (adv) begin
			mul_a_s1 <= op_a;
			mul_b_s1 <= op_b;
			add_c_s1 <= op_c;
			bpp_s1   <= bpp_cur;
			bip_s1   <= bip_q;
			plane_s1 <= plane_q;
			byte_s1  <= byte_stream.source_byte;
			last_s1  <= frame_done;

			idx_s2  <= AREA_W'(product + (CNT_W+DIM_W)'(add_c_s1));
			base_s2 <= base_nxt;
			bpp_s2  <= bpp_s1;
			bip_s2  <= bip_s1;
			byte_s2 <= byte_s1;
			last_s2 <= last_s1;

			addr_s3 <= addr_sum[ADDR_W-1:0];
			byte_s3 <= byte_s2;
			last_s3 <= last_s2;
		end
	end

`ifndef SYNTH
	// a configuration write always restarts the frame
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> (col_q == '0) && (row_q == '0) && (bip_q == '0) && (plane_q == PLANE_LUMA))
		else $error("counters not cleared after configuration write");

	// position counters stay inside the current plane
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(DIM_W'(col_q) < pw_cur) && (DIM_W'(row_q) < ph_cur) && ({1'b0, bip_q} < bpp_cur)
		&& (plane_q < nplanes))
		else $error("position counter out of range");

	// a dropped byte with rotation none leaves the counters still
	a_none_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (rotation_q == ROT_NONE) && !cfg_write) |=>
		$stable(col_q) && $stable(row_q) && $stable(bip_q) && $stable(plane_q))
		else $error("counters moved with rotation none");

	// a byte taken under rotation none creates no result
	a_none_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (rotation_q == ROT_NONE)) |=> !v_s1)
		else $error("result created with rotation none");
`endif

endmodule

// File: sim/tb_top.sv
// self-checking bench for the rotating scatter-address generator
module tb_top;
	import irsa_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int MAX_DIM        = 4096;
	localparam int ITEM_TARGET    = 1400;
	localparam int DRAIN_CYCLES   = 8;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int IDLE_PERCENT   = 8;

	// one expected placement of a source byte in the rotated frame
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
		logic              last;
	} placement_t;

	// predicts where each byte lands and keeps the placements still owed
	class scatter_scoreboard;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		logic [1:0]       rotation;
		logic [1:0]       layout;
		int unsigned      column;
		int unsigned      row;
		int unsigned      byte_pos;
		logic [1:0]       plane;
		placement_t       pending[$];
		int               errors;

		function new();
			width_reg  = RESET_WIDTH;
			height_reg = RESET_HEIGHT;
			rotation   = ROT_NONE;
			layout     = LAYOUT_PLANAR;
			errors     = 0;
			restart();
		endfunction

		function void restart();
			column   = 0;
			row      = 0;
			byte_pos = 0;
			plane    = PLANE_LUMA;
		endfunction

		function longint unsigned clamp_dim(logic [CFG_W-1:0] v);
			longint unsigned d;
			d = 64'({v[CFG_W-1:1], 1'b0});
			if (d < 2) d = 2;
			if (d > MAX_DIM) d = 64'(MAX_DIM);
			return d;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_FRAME_WIDTH: begin
					width_reg = data;
				end
				REG_FRAME_HEIGHT: begin
					height_reg = data;
				end
				REG_ROTATION: begin
					rotation = data[1:0];
				end
				default: begin
					layout = data[1:0];
				end
			endcase
			restart();
		endfunction

		// bytes in one whole frame at the current setting
		function longint unsigned frame_bytes();
			longint unsigned wh;
			wh = clamp_dim(width_reg) * clamp_dim(height_reg);
			case (layout)
				LAYOUT_RGB: begin
					return wh * 3;
				end
				LAYOUT_RGBA: begin
					return wh * 4;
				end
				default: begin
					return wh + wh / 2;
				end
			endcase
		endfunction

		// accepted source byte: work out its destination and step the counters
		function void note_input(logic [BYTE_W-1:0] b);
			longint unsigned w, h, pw, ph, base, bpp, planes, x, y, idx, addr;
			bit              last;
			placement_t      p;
			if (rotation == ROT_NONE) return;
			last = 0;
			w = clamp_dim(width_reg);
			h = clamp_dim(height_reg);
			if (layout == LAYOUT_RGB || layout == LAYOUT_RGBA) begin
				planes = 1;
				bpp    = (layout == LAYOUT_RGB) ? 3 : 4;
			end else begin
				planes = (layout == LAYOUT_PLANAR) ? 3 : 2;
				bpp    = 1;
			end
			if (plane >= planes) plane = PLANE_LUMA;
			if (plane == PLANE_LUMA) begin
				pw   = w;
				ph   = h;
				base = 0;
			end else begin
				pw   = w >> 1;
				ph   = h >> 1;
				base = (plane == PLANE_U) ? w * h : w * h + ((w * h) >> 2);
				// interleaved uv pairs
				if (layout == LAYOUT_SEMI) bpp = 2;
			end
			if (byte_pos >= bpp) byte_pos = 0;
			if (column >= pw) column = 0;
			if (row >= ph) row = 0;
			x = column;
			y = row;
			if (rotation == ROT_90)
				idx = x * ph + (ph - 1 - y);
			else if (rotation == ROT_180)
				idx = (ph - 1 - y) * pw + (pw - 1 - x);
			else
				idx = (pw - 1 - x) * ph + y;
			addr = base + idx * bpp + byte_pos;

			byte_pos++;
			if (byte_pos >= bpp) begin
				byte_pos = 0;
				column++;
				if (column >= pw) begin
					column = 0;
					row++;
					if (row >= ph) begin
						row = 0;
						plane++;
						if (plane >= planes) begin
							plane = PLANE_LUMA;
							last  = 1;
						end
					end
				end
			end
			p.addr = addr[ADDR_W-1:0];
			p.data = b;
			p.last = last;
			pending.push_back(p);
		endfunction

		function void check_result(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data,
			logic last);
			placement_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected placement: addr %0d byte %02h end %0b",
						addr, data, last);
				return;
			end
			e = pending.pop_front();
			if (addr !== e.addr || data !== e.data || last !== e.last) begin
				errors++;
				if (errors <= 10)
					$display({"placement mismatch: expected addr %0d byte %02h end %0b, ",
						"got addr %0d byte %02h end %0b"},
						e.addr, e.data, e.last, addr, data, last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	bit                   no_gaps = 1'b0;

	irsa_in_if  byte_ch ();
	irsa_out_if addr_ch ();

	scatter_scoreboard sb = new();

	image_rotate_scatter_address #(
		.MAX_DIM(MAX_DIM)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_stream(byte_ch.sink),
		.addr_stream(addr_ch.source)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// result side: check every transfer, then pick the next ready at random
	always @(posedge clk) begin
		if (arst_n && addr_ch.valid && addr_ch.ready)
			sb.check_result(addr_ch.dest_address, addr_ch.out_byte, addr_ch.frame_end);
		addr_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// hard stop in case a transfer never comes
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("tb_top failed");
		$finish;
	end

	// write the registers picked by mask, one per cycle; the frame restarts
	task automatic program_frame(logic [3:0] mask, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
		logic [1:0] rot, logic [1:0] lay);
		logic [CFG_W-1:0] junk;
		logic [CFG_W-1:0] data;
		for (int i = 0; i < 4; i++) begin
			if (mask[i]) begin
				// upper bits of the 2-bit registers carry noise the block must drop
				junk = CFG_W'($urandom);
				case (i[CFG_IDX_W-1:0])
					REG_FRAME_WIDTH:  data = w;
					REG_FRAME_HEIGHT: data = h;
					REG_ROTATION:     data = {junk[CFG_W-1:2], rot};
					default:          data = {junk[CFG_W-1:2], lay};
				endcase
				cfg_write <= 1'b1;
				cfg_index <= i[CFG_IDX_W-1:0];
				cfg_data  <= data;
				@(posedge clk);
				sb.write_reg(i[CFG_IDX_W-1:0], data);
			end
		end
		cfg_write <= 1'b0;
	endtask

	// one source byte, with a random gap ahead of it
	task automatic send_byte(logic [BYTE_W-1:0] b);
		if (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.source_byte <= b;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		sb.note_input(b);
	endtask

	task automatic send_random(int n);
		for (int i = 0; i < n; i++) send_byte(BYTE_W'($urandom));
	endtask

	// stop sending, let every owed placement arrive, then cover the pipeline depth
	task automatic wait_idle();
		byte_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int                    counted;
		int                    kind;
		int                    n;
		longint unsigned       fb;
		logic [3:0]            mask;
		logic [CFG_W-1:0]      w;
		logic [CFG_W-1:0]      h;
		logic [1:0]            rot;
		logic [1:0]            lay;
		logic [CFG_W-1:0]      big_dims[5];

		big_dims = '{13'd4094, 13'd4096, 13'd4097, 13'd6000, 13'd8191};
		arst_n              = 1'b0;
		cfg_write           = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		byte_ch.valid       = 1'b0;
		byte_ch.source_byte = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting has rotation none: bytes are taken and dropped
		send_byte(8'h00);
		send_byte(8'hFF);
		wait_idle();

		// smallest planar frame, whole, so frame_end shows up
		program_frame(4'hF, 13'd2, 13'd2, ROT_90, LAYOUT_PLANAR);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'h01);
		send_byte(8'h80);
		wait_idle();

		// width of one clears to zero and is lifted to two, all-ones height clamps
		program_frame(4'hF, 13'd1, 13'h1FFF, ROT_270, LAYOUT_RGBA);
		send_random(3);
		wait_idle();

		// width just over the limit drops to it once its low bit clears, zero height is lifted to two
		program_frame(4'hF, 13'd4097, 13'd0, ROT_180, LAYOUT_SEMI);
		send_random(3);
		wait_idle();

		// whole semi-planar frame
		program_frame(4'hF, 13'd2, 13'd2, ROT_270, LAYOUT_SEMI);
		send_random(6);
		wait_idle();

		// odd width, then a lone rotation write restarts mid-frame
		program_frame(4'hF, 13'd3, 13'd2, ROT_180, LAYOUT_RGB);
		send_random(4);
		wait_idle();
		program_frame(4'b0100, 13'd0, 13'd0, ROT_180, LAYOUT_RGB);
		send_random(2);
		wait_idle();

		// random phases: mostly whole small frames, some big or odd sizes cut short
		counted = 0;
		while (counted < ITEM_TARGET) begin
			// a long stretch where neither side idles
			no_gaps = (counted >= ITEM_TARGET / 4) && (counted < ITEM_TARGET * 3 / 5);
			kind = $urandom_range(0, 15);
			if (kind == 0) begin
				w = big_dims[$urandom_range(0, 4)];
				h = $urandom_range(0, 1) ? big_dims[$urandom_range(0, 4)]
					: 13'(2 * $urandom_range(1, 4));
			end else if (kind == 1) begin
				w = CFG_W'($urandom_range(0, 7));
				h = CFG_W'($urandom_range(0, 7));
			end else begin
				w = 13'(2 * $urandom_range(1, 4));
				h = 13'(2 * $urandom_range(1, 4));
			end
			rot  = ($urandom_range(0, 9) == 0) ? ROT_NONE : 2'($urandom_range(1, 3));
			lay  = 2'($urandom_range(0, 3));
			mask = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15)) : 4'hF;
			program_frame(mask, w, h, rot, lay);

			fb = sb.frame_bytes();
			if (sb.rotation == ROT_NONE)
				n = $urandom_range(3, 8);
			else if (fb <= 260)
				n = int'(fb) * $urandom_range(1, 2) + $urandom_range(0, int'(fb) - 1);
			else
				n = $urandom_range(16, 48);
			// keep the total near the target
			if (sb.rotation != ROT_NONE && n > ITEM_TARGET - counted)
				n = ITEM_TARGET - counted;
			send_random(n);
			if (sb.rotation != ROT_NONE) counted += n;
			wait_idle();
		end

		// anything still owed at this point is a failure
		sb.errors += sb.pending.size();
		if (sb.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
